FILE: rtl/core/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg: shared types and constants of the nick challenge checksum
// Holds the field widths, the mixing constants, the register indexes and the
// controller state type that the interfaces and the core use.
// ----------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

   // Field widths of the words on each channel.
   localparam int NAME_BYTE_W = 8;
   localparam int CHECKSUM_W  = 16;
   localparam int HASH_W      = 32;

   // Configuration port: two registers, one index bit.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ADDRESS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHALLENGE_WORD = 1'd1;

   // Constants XORed in after each shift, chosen by the bit shifted out.
   localparam logic [HASH_W-1:0] POLY_HIGH = 32'ha67f3443;
   localparam logic [HASH_W-1:0] POLY_LOW  = 32'h378624e5;

   // Step counter within one byte: step 0 mixes, steps 1 to 8 shift.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_MIX  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_HASH    = 3'b010,
      ST_HOLD    = 3'b100
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/ncc_req_if.sv
// ----------------------------------------------------------------------------
// ncc_req_if: name byte channel
// Valid/ready channel that carries one name byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ncc_pkg::NAME_BYTE_W-1:0]  name_byte;

   modport source (output valid, output name_byte, input ready);
   modport sink   (input valid, input name_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ncc_rsp_if.sv
// ----------------------------------------------------------------------------
// ncc_rsp_if: checksum channel
// Valid/ready channel that carries one 16-bit checksum per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ncc_pkg::CHECKSUM_W-1:0]  checksum;

   modport source (output valid, output checksum, input ready);
   modport sink   (input valid, input checksum, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nick_challenge_checksum.sv
// ----------------------------------------------------------------------------
// nick_challenge_checksum: name checksum with seed and challenge
// Collects NAME_LEN name bytes, then runs a bit-serial keyed hash over them
// and returns the low 16 bits of the hash register.
// ----------------------------------------------------------------------------
// Usage: send the bytes of a name in order on req; every NAME_LEN-th word
// closes a name and produces one checksum word on rsp. req stays ready after
// a byte that does not close a name. After the closing byte the hash runs
// one step per cycle: each byte takes one mixing step for byte and
// challenge, then eight shift steps, the last of which also adds the byte.
// The hash uses a single 32-bit shift register and its step counter. req is
// not ready while the hash runs; bytes of the next name are taken while a
// checksum still waits on rsp. The seed and challenge registers are read
// during the hash, so write them only while no name is being hashed.
`default_nettype none

module nick_challenge_checksum #(
   parameter int ROUNDS   = 10,
   parameter int NAME_LEN = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ncc_req_if.sink                              req,
   ncc_rsp_if.source                            rsp,
   input  wire logic                            csr_we,
   input  wire logic [ncc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ncc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int BYTE_W  = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
   localparam int ROUND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [BYTE_W-1:0]  BYTE_LAST  = BYTE_W'(NAME_LEN - 1);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

   ncc_pkg::state_type state_ff, state_in;
   logic [BYTE_W-1:0]          byte_ff, byte_in;
   logic [ROUND_W-1:0]         round_ff, round_in;
   logic [ncc_pkg::STEP_W-1:0] step_ff, step_in;
   logic [ncc_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [ncc_pkg::HASH_W-1:0] seed_ff, chal_ff;
   logic [ncc_pkg::NAME_BYTE_W-1:0] store_ff [NAME_LEN];
   logic [ncc_pkg::NAME_BYTE_W-1:0] tail_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ncc_pkg::CHECKSUM_W-1:0] rsp_sum_ff;

   logic req_accept, last_byte, last_step, last_round, load_rsp, store_shift;
   logic [ncc_pkg::HASH_W-1:0] shifted;

   assign req_accept = req.valid && req.ready;
   assign last_byte  = (byte_ff == BYTE_LAST);
   assign last_step  = (step_ff == ncc_pkg::STEP_LAST);
   assign last_round = (round_ff == ROUND_LAST);
   assign load_rsp   = (state_ff == ncc_pkg::ST_HOLD) && (!rsp_valid_ff || rsp.ready);

   assign req.ready    = (state_ff == ncc_pkg::ST_COLLECT);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.checksum = rsp_sum_ff;

   // One shift step: shift left, then XOR the constant picked by the top bit.
   assign shifted = {hash_ff[ncc_pkg::HASH_W-2:0], 1'b0} ^
                    (hash_ff[ncc_pkg::HASH_W-1] ? ncc_pkg::POLY_HIGH : ncc_pkg::POLY_LOW);

   // Controller and hash datapath.
   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      round_in = round_ff;
      step_in  = step_ff;
      hash_in  = hash_ff;
      unique case (state_ff)
         ncc_pkg::ST_COLLECT: begin
            if (req_accept) begin
               if (last_byte) begin
                  byte_in  = '0;
                  round_in = '0;
                  step_in  = ncc_pkg::STEP_MIX;
                  hash_in  = seed_ff;
                  state_in = ncc_pkg::ST_HASH;
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end
         end
         ncc_pkg::ST_HASH: begin
            if (step_ff == ncc_pkg::STEP_MIX) begin
               hash_in = hash_ff ^ chal_ff ^
                         {store_ff[0], {(ncc_pkg::HASH_W - ncc_pkg::NAME_BYTE_W){1'b0}}};
               step_in = step_ff + 1'b1;
            end else if (last_step) begin
               hash_in = shifted +
                         {{(ncc_pkg::HASH_W - ncc_pkg::NAME_BYTE_W){1'b0}}, store_ff[0]};
               step_in = ncc_pkg::STEP_MIX;
               if (last_byte) begin
                  byte_in = '0;
                  if (last_round) begin
                     state_in = ncc_pkg::ST_HOLD;
                  end else begin
                     round_in = round_ff + 1'b1;
                  end
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end else begin
               hash_in = shifted;
               step_in = step_ff + 1'b1;
            end
         end
         ncc_pkg::ST_HOLD: begin
            if (load_rsp) begin
               state_in = ncc_pkg::ST_COLLECT;
            end
         end
         default: begin
            state_in = ncc_pkg::ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ncc_pkg::ST_COLLECT;
         byte_ff  <= '0;
         round_ff <= '0;
         step_ff  <= ncc_pkg::STEP_MIX;
         hash_ff  <= '0;
      end else begin
         state_ff <= state_in;
         byte_ff  <= byte_in;
         round_ff <= round_in;
         step_ff  <= step_in;
         hash_ff  <= hash_in;
      end
   end

   // The name store is a byte shift line: bytes enter at the tail while
   // collecting, and the line rotates by one byte after each hashed byte,
   // so the byte being hashed always sits at the head.
   assign store_shift = req_accept ||
                        ((state_ff == ncc_pkg::ST_HASH) && last_step);
   assign tail_in     = (state_ff == ncc_pkg::ST_COLLECT) ? req.name_byte : store_ff[0];

   always_ff @(posedge clock) begin
      if (store_shift) begin
         for (int i = 0; i < NAME_LEN - 1; i++) begin
            store_ff[i] <= store_ff[i + 1];
         end
         store_ff[NAME_LEN - 1] <= tail_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         chal_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ncc_pkg::CSR_SEED_ADDRESS:   seed_ff <= csr_wdata;
            ncc_pkg::CSR_CHALLENGE_WORD: chal_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Output register: holds the checksum word until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sum_ff <= hash_ff[ncc_pkg::CHECKSUM_W-1:0];
      end
   end

   // A closing byte starts the hash from the seed at the mixing step.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && last_byte) |=>
         (state_ff == ncc_pkg::ST_HASH) && (step_ff == ncc_pkg::STEP_MIX) &&
         (hash_ff == $past(seed_ff)))
      else $error("hash did not start from the seed after the closing byte");

   // A checksum word appears only from the hold state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ncc_pkg::ST_HOLD))
      else $error("checksum offered without a finished hash");

   // The step counter never runs past the last shift step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ncc_pkg::ST_HASH) |-> (step_ff <= ncc_pkg::STEP_LAST))
      else $error("step counter out of range");

   // The hold state is reached only at the last step of the last byte.
   assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ncc_pkg::ST_HOLD) |->
         $past(last_step && last_byte && last_round))
      else $error("hash finished early");

endmodule

`default_nettype wire

FILE: dv/nick_challenge_checksum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nick_challenge_checksum_tb: self-checking bench for the name checksum block
// Streams name bytes with random gaps on both channels, rewrites the seed and
// the challenge between phases, and checks every checksum word against a
// keyed hash that the bench computes from the bytes it has seen accepted.
// ----------------------------------------------------------------------------
module nick_challenge_checksum_tb;

   localparam int ROUNDS   = 10;
   localparam int NAME_LEN = 12;

   // Constants applied after each shift, selected by the bit shifted out.
   localparam logic [31:0] SHIFT_OUT_ONE  = 32'ha67f3443;
   localparam logic [31:0] SHIFT_OUT_ZERO = 32'h378624e5;

   localparam int MAX_GAP      = 18;
   localparam int LONG_HOLD    = 4000;
   localparam int SETTLE       = 16;
   localparam int TAIL         = 100;
   localparam int RANDOM_ITEMS = 450;
   localparam int MIN_NAMES    = 36;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int REPORT_MAX   = 10;

   // One row of the directed table: a name byte or a register write.
   typedef enum logic {
      ROW_BYTE = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [ncc_pkg::CSR_IDX_W-1:0]    index;
      logic [ncc_pkg::CSR_DATA_W-1:0]   data;
   } stim_row_type;

   localparam int DIRECTED_ROWS  = 27;
   localparam int DIRECTED_BYTES = 24;

   // First name: all zero bytes with the registers as reset left them.
   // Second name: all-ones registers, then a seed rewrite in mid-name, which
   // must take effect since the seed is only read when the name closes.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h00},
      '{ROW_CSR,  ncc_pkg::CSR_SEED_ADDRESS,   32'hffffffff},
      '{ROW_CSR,  ncc_pkg::CSR_CHALLENGE_WORD, 32'hffffffff},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hff}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hff},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hff}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hff},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hff},
      '{ROW_CSR,  ncc_pkg::CSR_SEED_ADDRESS, 32'h00000000},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h01}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h80},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h7f}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hfe},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'h55}, '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'haa},
      '{ROW_BYTE, ncc_pkg::CSR_SEED_ADDRESS, 32'hff}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_we;
   logic [ncc_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [ncc_pkg::CSR_DATA_W-1:0]    csr_wdata;

   ncc_req_if req_ch ();
   ncc_rsp_if rsp_ch ();

   // Bench copy of the block state and of its two registers.
   logic [7:0]   name_held [NAME_LEN];
   int unsigned  bytes_held = 0;
   logic [31:0]  seed_shadow = '0;
   logic [31:0]  challenge_shadow = '0;
   logic [15:0]  checksum_due [$];

   int unsigned  items_taken = 0;
   int unsigned  names_closed = 0;
   int unsigned  faults = 0;
   int unsigned  cycle_count = 0;
   bit           req_quiet = 1'b0;
   bit           rsp_quiet = 1'b0;
   bit           hold_armed = 1'b0;

   nick_challenge_checksum #(
      .ROUNDS   (ROUNDS),
      .NAME_LEN (NAME_LEN)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[nick_challenge_checksum] ERROR");
         $finish;
      end
   end

   // Keyed hash over the held name: ROUNDS passes, one mixing step per byte.
   function automatic logic [31:0] name_hash();
      logic [31:0] acc;
      acc = seed_shadow;
      for (int round = 0; round < ROUNDS; round++) begin
         for (int i = 0; i < NAME_LEN; i++) begin
            acc ^= {name_held[i], 24'h000000};
            acc ^= challenge_shadow;
            for (int k = 0; k < 8; k++) begin
               acc = acc[31] ? ((acc << 1) ^ SHIFT_OUT_ONE) : ((acc << 1) ^ SHIFT_OUT_ZERO);
            end
            acc += {24'h000000, name_held[i]};
         end
      end
      return acc;
   endfunction

   // Store an accepted byte; the byte that closes a name queues its checksum.
   function automatic void absorb_name_byte(input logic [7:0] value);
      logic [31:0] hash_word;
      name_held[bytes_held] = value;
      bytes_held++;
      items_taken++;
      if (bytes_held == NAME_LEN) begin
         bytes_held = 0;
         names_closed++;
         hash_word = name_hash();
         checksum_due.push_back(hash_word[15:0]);
      end
   endfunction

   function automatic void log_fault(input string what, input logic [15:0] want,
                                     input logic [15:0] got);
      faults++;
      if (faults <= REPORT_MAX)
         $display("checksum %s: expected %h, got %h (cycle %0d)", what, want, got, cycle_count);
   endfunction

   // Offer one name byte after a random gap and wait until it is taken.
   task automatic send_name_byte(input logic [7:0] value);
      int unsigned gap;
      if ($urandom_range(0, 15) == 0)
         req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.name_byte <= value;
      do @(posedge clock); while (!req_ch.ready);
      absorb_name_byte(value);
   endtask

   // Stop offering, wait for every queued checksum, then let the block settle.
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      while (checksum_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_config(input bit set_seed, input logic [31:0] seed,
                              input bit set_chal, input logic [31:0] chal);
      if (set_seed) begin
         csr_we    <= 1'b1;
         csr_index <= ncc_pkg::CSR_SEED_ADDRESS;
         csr_wdata <= seed;
         @(posedge clock);
         seed_shadow = seed;
      end
      if (set_chal) begin
         csr_we    <= 1'b1;
         csr_index <= ncc_pkg::CSR_CHALLENGE_WORD;
         csr_wdata <= chal;
         @(posedge clock);
         challenge_shadow = chal;
      end
      csr_we <= 1'b0;
   endtask

   // Name byte source: directed table first, then random phases.
   initial begin : stimulus
      stim_row_type row;
      int unsigned  phase_len;
      int unsigned  phase;
      logic [31:0]  seed_pick;
      logic [31:0]  chal_pick;
      logic [7:0]   next_byte;
      bit           set_seed;
      bit           set_chal;

      req_ch.valid     <= 1'b0;
      req_ch.name_byte <= '0;
      csr_we           <= 1'b0;
      csr_index        <= ncc_pkg::CSR_SEED_ADDRESS;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED[r];
         if (row.kind == ROW_CSR) begin
            settle_idle();
            if (row.index == ncc_pkg::CSR_SEED_ADDRESS)
               load_config(1'b1, row.data, 1'b0, '0);
            else
               load_config(1'b0, '0, 1'b1, row.data);
         end else begin
            send_name_byte(row.data[7:0]);
         end
      end

      // Random phases: new register values, then mostly whole names. Some
      // phases stop in mid-name so the next rewrite lands during collection.
      phase = 0;
      while (items_taken < DIRECTED_BYTES + RANDOM_ITEMS || names_closed < MIN_NAMES) begin
         settle_idle();
         case ($urandom_range(0, 2))
            0:       seed_pick = 32'h00000000;
            1:       seed_pick = 32'hffffffff;
            default: seed_pick = $urandom;
         endcase
         case ($urandom_range(0, 2))
            0:       chal_pick = 32'h00000000;
            1:       chal_pick = 32'hffffffff;
            default: chal_pick = $urandom;
         endcase
         set_seed = $urandom_range(0, 1);
         set_chal = !set_seed || ($urandom_range(0, 1) == 1);
         load_config(set_seed, seed_pick, set_chal, chal_pick);

         // One long phase during which the checksum side holds off, so the
         // block fills with the next name and stalls its byte input.
         if (phase == 3) begin
            hold_armed = 1'b1;
            phase_len  = (NAME_LEN - bytes_held) + 3 * NAME_LEN;
         end else if ($urandom_range(0, 3) != 0) begin
            phase_len = (NAME_LEN - bytes_held) + NAME_LEN * $urandom_range(0, 2);
         end else begin
            phase_len = $urandom_range(1, 30);
         end

         repeat (phase_len) begin
            case ($urandom_range(0, 9))
               0:       next_byte = 8'h00;
               1:       next_byte = 8'hff;
               default: next_byte = $urandom_range(0, 255);
            endcase
            send_name_byte(next_byte);
         end
         phase++;
      end

      settle_idle();
      repeat (TAIL) @(posedge clock);
      if (faults == 0)
         $display("[nick_challenge_checksum] OK");
      else
         $display("[nick_challenge_checksum] ERROR");
      $finish;
   end

   // Checksum sink: random ready gaps, one long hold, and the word check.
   initial begin : checksum_drain
      int unsigned  gap;
      logic [15:0]  want;

      rsp_ch.ready <= 1'b0;
      gap = $urandom_range(0, MAX_GAP);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (checksum_due.size() == 0) begin
               log_fault("unexpected", 'x, rsp_ch.checksum);
            end else begin
               want = checksum_due.pop_front();
               if (rsp_ch.checksum !== want)
                  log_fault("mismatch", want, rsp_ch.checksum);
            end
            if ($urandom_range(0, 15) == 0)
               rsp_quiet = !rsp_quiet;
            gap = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_armed) begin
               gap        = LONG_HOLD;
               hold_armed = 1'b0;
            end
            if (gap != 0)
               rsp_ch.ready <= 1'b0;
         end else if (!rsp_ch.ready) begin
            if (gap != 0)
               gap--;
            if (gap == 0)
               rsp_ch.ready <= 1'b1;
         end
      end
   end

endmodule
